// ===== rtl/decimated_rms_level_meter_macros.svh =====
// Assertion macros shared by the level meter RTL.
// No dependencies; each module that asserts includes this header.
`ifndef DECIMATED_RMS_LEVEL_METER_MACROS_SVH
`define DECIMATED_RMS_LEVEL_METER_MACROS_SVH
`ifndef ASSERT_OFF
`define DRLM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DRLM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DRLM_ASSERT(label, prop, msg)
`define DRLM_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/drlm_pkg.sv =====
// Package for the level meter: field widths, register codes, controller states
// and the command and status bundles between controller and datapath.
// No dependencies.
package drlm_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int GAIN_BITS      = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int RMS_BITS       = 16;
    localparam int CHAN_BITS      = 2;
    localparam int DEC_BITS       = 5;
    localparam int PHASE_BITS     = 4;
    localparam int MAX_DECIMATION = 16;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ENABLE        = 8'd0,
        REG_CHANNEL_COUNT = 8'd1,
        REG_DECIMATION    = 8'd2,
        REG_GAIN          = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic                 enable;
        logic [CHAN_BITS-1:0] channel_count;
        logic [DEC_BITS-1:0]  decimation;
        logic [GAIN_BITS-1:0] gain;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        enable:        1'b1,
        channel_count: 2'd1,
        decimation:    5'd4,
        gain:          16'd256
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_DIV_INIT,
        ST_DIV,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_SCALE,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic load;
        logic square;
        logic accum;
        logic clear_res;
        logic div_start;
        logic div_step;
        logic sqrt_start;
        logic sqrt_step;
        logic scale;
        logic out_load;
        logic chan;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic used_zero;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/drlm_ifs.sv =====
// Channel interfaces of the level meter: input frames, results and register writes.
// Depends on drlm_pkg.
interface drlm_frame_if import drlm_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
    logic                          last_frame;

    modport source (output valid, output sample_left, output sample_right,
                    output last_frame, input ready);
    modport sink   (input valid, input sample_left, input sample_right,
                    input last_frame, output ready);
endinterface

interface drlm_result_if import drlm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [RMS_BITS-1:0] rms_left;
    logic [RMS_BITS-1:0] rms_right;
    logic                saturated;

    modport source (output valid, output rms_left, output rms_right,
                    output saturated, input ready);
    modport sink   (input valid, input rms_left, input rms_right,
                    input saturated, output ready);
endinterface

interface drlm_cfg_if import drlm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/drlm_datapath.sv =====
// Datapath of the level meter: accumulators, decimation phase, serial divider,
// serial square root, gain multiplier and output register.
// Depends on drlm_pkg and the assertion macro header.
`include "decimated_rms_level_meter_macros.svh"
module drlm_datapath import drlm_pkg::*; #(
    parameter int MAX_FRAMES = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_t                          cfg,
    input  cmd_t                          cmd,
    output status_t                       status,
    input  logic signed [SAMPLE_BITS-1:0] sample_left,
    input  logic signed [SAMPLE_BITS-1:0] sample_right,
    input  logic                          last_frame,
    input  logic                          res_ready,
    output logic                          res_valid,
    output logic [RMS_BITS-1:0]           rms_left,
    output logic [RMS_BITS-1:0]           rms_right,
    output logic                          saturated
);

    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
    localparam int SQ_W       = 2 * SAMPLE_BITS;
    localparam int QUO_W      = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W      = QUO_W + $clog2(MAX_FRAMES);
    localparam int DIV_CNT_W  = $clog2(SUM_W);
    localparam int ROOT_CNT_W = $clog2(SAMPLE_BITS);
    localparam int SREM_W     = SAMPLE_BITS + 2;
    localparam int PROD_W     = SAMPLE_BITS + GAIN_BITS;
    localparam int SCALED_W   = PROD_W - GAIN_FRAC_BITS;

    // Payload registers.
    logic signed [SAMPLE_BITS-1:0] smp_left_reg, smp_right_reg;
    logic [SQ_W-1:0]               sq_left_reg, sq_left_next;
    logic [SQ_W-1:0]               sq_right_reg, sq_right_next;
    logic [SUM_W-1:0]              quo_reg, quo_next;
    logic [CNT_W-1:0]              rem_reg, rem_next;
    logic [SQ_W-1:0]               rad_reg, rad_next;
    logic [SAMPLE_BITS-1:0]        root_reg, root_next;
    logic [SREM_W-1:0]             srem_reg, srem_next;
    logic [RMS_BITS-1:0]           res_left_reg, res_left_next;
    logic [RMS_BITS-1:0]           res_right_reg, res_right_next;
    logic                          sat_reg, sat_next;
    logic [RMS_BITS-1:0]           out_left_reg, out_left_next;
    logic [RMS_BITS-1:0]           out_right_reg, out_right_next;
    logic                          out_sat_reg, out_sat_next;

    // Control state.
    logic                   last_reg, last_next;
    logic [SUM_W-1:0]       sum_left_reg, sum_left_next;
    logic [SUM_W-1:0]       sum_right_reg, sum_right_next;
    logic [PHASE_BITS-1:0]  phase_reg, phase_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [ROOT_CNT_W-1:0]  root_cnt_reg, root_cnt_next;
    logic                   out_valid_reg, out_valid_next;

    logic                   two_chan;
    logic [DEC_BITS-1:0]    dec_eff;
    logic [PHASE_BITS:0]    phase_inc;
    logic                   use_frame;
    logic [SAMPLE_BITS-1:0] mag_left, mag_right;
    logic [CNT_W:0]         div_trial;
    logic [CNT_W:0]         div_diff;
    logic                   div_ge;
    logic [SREM_W+1:0]      sqrt_shifted;
    logic [SREM_W+1:0]      sqrt_trial;
    logic                   sqrt_ge;
    logic [PROD_W-1:0]      product;
    logic [SCALED_W-1:0]    scaled;
    logic                   clip;
    logic [RMS_BITS-1:0]    clipped_val;

    function automatic logic [SAMPLE_BITS-1:0] magnitude(
        input logic signed [SAMPLE_BITS-1:0] v
    );
        magnitude = v[SAMPLE_BITS-1] ? SAMPLE_BITS'(~v + 1'b1) : SAMPLE_BITS'(v);
    endfunction

    // A channel count of two or three means stereo.
    assign two_chan  = cfg.channel_count[1];
    assign dec_eff   = (cfg.decimation == '0) ? DEC_BITS'(1) :
                       (cfg.decimation > DEC_BITS'(MAX_DECIMATION)) ?
                       DEC_BITS'(MAX_DECIMATION) : cfg.decimation;
    assign phase_inc = {1'b0, phase_reg} + 1'b1;
    assign use_frame = (phase_reg == '0) && (used_reg < CNT_W'(MAX_FRAMES));

    assign mag_left  = magnitude(smp_left_reg);
    assign mag_right = magnitude(smp_right_reg);

    // One quotient bit per step, restoring division by the used frame count.
    assign div_trial = {rem_reg, quo_reg[SUM_W-1]};
    assign div_ge    = div_trial >= {1'b0, used_reg};
    assign div_diff  = div_trial - {1'b0, used_reg};

    // One root bit per step, two radicand bits consumed each time.
    assign sqrt_shifted = {srem_reg, rad_reg[SQ_W-1 -: 2]};
    assign sqrt_trial   = {2'b00, root_reg, 2'b01};
    assign sqrt_ge      = sqrt_shifted >= sqrt_trial;

    assign product     = PROD_W'(root_reg) * PROD_W'(cfg.gain);
    assign scaled      = product[PROD_W-1:GAIN_FRAC_BITS];
    assign clip        = |scaled[SCALED_W-1:RMS_BITS];
    assign clipped_val = clip ? '1 : scaled[RMS_BITS-1:0];

    always_comb
    begin
        last_next      = last_reg;
        sq_left_next   = sq_left_reg;
        sq_right_next  = sq_right_reg;
        sum_left_next  = sum_left_reg;
        sum_right_next = sum_right_reg;
        phase_next     = phase_reg;
        used_next      = used_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        srem_next      = srem_reg;
        root_cnt_next  = root_cnt_reg;
        res_left_next  = res_left_reg;
        res_right_next = res_right_reg;
        sat_next       = sat_reg;
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;
        out_sat_next   = out_sat_reg;
        out_valid_next = out_valid_reg && !res_ready;

        if (cmd.load)
        begin
            last_next = last_frame;
        end
        if (cmd.square)
        begin
            sq_left_next  = SQ_W'(mag_left) * SQ_W'(mag_left);
            sq_right_next = SQ_W'(mag_right) * SQ_W'(mag_right);
        end
        if (cmd.accum)
        begin
            if (use_frame)
            begin
                sum_left_next = sum_left_reg + SUM_W'(sq_left_reg);
                if (two_chan)
                begin
                    sum_right_next = sum_right_reg + SUM_W'(sq_right_reg);
                end
                used_next = used_reg + 1'b1;
            end
            phase_next = (phase_inc >= PHASE_BITS'(0) + {1'b0, dec_eff[PHASE_BITS-1:0]}
                          && dec_eff != DEC_BITS'(MAX_DECIMATION)) ||
                         (phase_inc >= (PHASE_BITS+1)'(dec_eff)) ?
                         '0 : phase_inc[PHASE_BITS-1:0];
        end
        if (cmd.clear_res)
        begin
            res_left_next  = '0;
            res_right_next = '0;
            sat_next       = 1'b0;
        end
        if (cmd.div_start)
        begin
            quo_next     = cmd.chan ? sum_right_reg : sum_left_reg;
            rem_next     = '0;
            div_cnt_next = '0;
        end
        if (cmd.div_step)
        begin
            rem_next     = div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
            quo_next     = {quo_reg[SUM_W-2:0], div_ge};
            div_cnt_next = div_cnt_reg + 1'b1;
        end
        if (cmd.sqrt_start)
        begin
            // The mean of squares never exceeds one full-scale square.
            rad_next      = {1'b0, quo_reg[QUO_W-1:0]};
            root_next     = '0;
            srem_next     = '0;
            root_cnt_next = '0;
        end
        if (cmd.sqrt_step)
        begin
            srem_next     = sqrt_ge ? SREM_W'(sqrt_shifted - sqrt_trial)
                                    : sqrt_shifted[SREM_W-1:0];
            root_next     = {root_reg[SAMPLE_BITS-2:0], sqrt_ge};
            rad_next      = {rad_reg[SQ_W-3:0], 2'b00};
            root_cnt_next = root_cnt_reg + 1'b1;
        end
        if (cmd.scale)
        begin
            if (cmd.chan)
            begin
                res_right_next = clipped_val;
            end
            else
            begin
                res_left_next = clipped_val;
            end
            sat_next = sat_reg || clip;
        end
        if (cmd.out_load)
        begin
            out_left_next  = res_left_reg;
            out_right_next = res_right_reg;
            out_sat_next   = sat_reg;
            out_valid_next = 1'b1;
            sum_left_next  = '0;
            sum_right_next = '0;
            phase_next     = '0;
            used_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= 1'b0;
            sum_left_reg  <= '0;
            sum_right_reg <= '0;
            phase_reg     <= '0;
            used_reg      <= '0;
            div_cnt_reg   <= '0;
            root_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            last_reg      <= last_next;
            sum_left_reg  <= sum_left_next;
            sum_right_reg <= sum_right_next;
            phase_reg     <= phase_next;
            used_reg      <= used_next;
            div_cnt_reg   <= div_cnt_next;
            root_cnt_reg  <= root_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            smp_left_reg  <= sample_left;
            smp_right_reg <= sample_right;
        end
        sq_left_reg   <= sq_left_next;
        sq_right_reg  <= sq_right_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        rad_reg       <= rad_next;
        root_reg      <= root_next;
        srem_reg      <= srem_next;
        res_left_reg  <= res_left_next;
        res_right_reg <= res_right_next;
        sat_reg       <= sat_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        out_sat_reg   <= out_sat_next;
    end

    assign status.last      = last_reg;
    assign status.used_zero = (used_reg == '0);
    assign status.div_done  = (div_cnt_reg == DIV_CNT_W'(SUM_W - 1));
    assign status.sqrt_done = (root_cnt_reg == ROOT_CNT_W'(SAMPLE_BITS - 1));
    assign status.out_free  = !out_valid_reg || res_ready;

    assign res_valid = out_valid_reg;
    assign rms_left  = out_left_reg;
    assign rms_right = out_right_reg;
    assign saturated = out_sat_reg;

    `DRLM_ASSERT(a_state_cleared, cmd.out_load |=> used_reg == '0 && phase_reg == '0, "block state not cleared after result")
    `DRLM_ASSERT_ALWAYS(a_used_bound, used_reg <= CNT_W'(MAX_FRAMES), "used frame count above limit")
    `DRLM_ASSERT(a_div_nonzero, cmd.div_start |-> used_reg != '0, "division started with zero frame count")

endmodule

// ===== rtl/drlm_ctrl.sv =====
// Controller of the level meter: sequences accumulation per frame and the
// per-channel divide, square root and scale steps at the end of a block.
// Depends on drlm_pkg and the assertion macro header.
`include "decimated_rms_level_meter_macros.svh"
module drlm_ctrl import drlm_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    frame_valid,
    output logic    frame_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   chan_reg, chan_next;

    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (frame_valid && cfg.enable)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                chan_next  = 1'b0;
                state_next = status.last ? ST_DIV_INIT : ST_IDLE;
            end
            ST_DIV_INIT:
            begin
                state_next = status.used_zero ? ST_OUTPUT : ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_SQRT_INIT;
                end
            end
            ST_SQRT_INIT:
            begin
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (status.sqrt_done)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (!chan_reg && cfg.channel_count[1])
                begin
                    chan_next  = 1'b1;
                    state_next = ST_DIV_INIT;
                end
                else
                begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.chan    = chan_reg;
        frame_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                frame_ready = 1'b1;
                cmd.load    = frame_valid && cfg.enable;
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
            end
            ST_ACCUM:
            begin
                cmd.accum     = 1'b1;
                cmd.clear_res = status.last;
            end
            ST_DIV_INIT:
            begin
                cmd.div_start = !status.used_zero;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_SQRT_INIT:
            begin
                cmd.sqrt_start = 1'b1;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
            end
            ST_SCALE:
            begin
                cmd.scale = 1'b1;
            end
            ST_OUTPUT:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd.chan = chan_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chan_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
        end
    end

    `DRLM_ASSERT(a_plain_frame_returns, state_reg == ST_ACCUM && !status.last |=> state_reg == ST_IDLE, "non-final frame did not return to idle")
    `DRLM_ASSERT(a_second_chan_final, state_reg == ST_SCALE && chan_reg |=> state_reg == ST_OUTPUT, "second channel scale not followed by output")
    `DRLM_ASSERT(a_chan_from_scale, $rose(chan_reg) |-> $past(state_reg) == ST_SCALE, "channel select changed outside scale step")

endmodule

// ===== rtl/decimated_rms_level_meter.sv =====
// Top level of the decimated block RMS level meter: register file and the
// controller and datapath instances. Depends on drlm_pkg, drlm_ifs, drlm_ctrl
// and drlm_datapath.
//
// The meter takes one stereo frame per item and, within a block of frames,
// uses the first frame and then every "decimation"-th one, summing the square
// of each used sample per channel (only the left channel when channel_count is
// one). On the frame marked last_frame it divides each sum by the number of
// frames used, takes the floor square root, applies the Q8.8 gain, clips to
// 16 bits and delivers one result item, then starts a new block. While enable
// is low, frames are taken and dropped. Once MAX_FRAMES frames have been used,
// further frames of the block are not counted. An ordinary frame passes through
// capture, square and accumulate steps before the input is ready again. A final
// frame then runs, for each active channel, a divide setup, one serial divider
// step per quotient bit of the SUM_W-bit sum, where SUM_W = 31 + log2(MAX_FRAMES)
// rounded up, a square-root setup, one square-root step per root bit and a scale
// step, and finally an output step that waits for a free output register.
// The result sits in an output register, so the next block's frames are
// accepted while a result waits; a second final frame waits for it to be taken.
// Registers: 0 enable, 1 channel_count, 2 decimation, 3 gain. The configuration
// channel is always ready, and other indexes are ignored. The controller reads
// the registers while it works on a frame, so a write belongs between frames,
// when no frame is being processed and no result is being computed; a change
// between two frames of a block takes effect from the next frame.
module decimated_rms_level_meter import drlm_pkg::*; #(
    parameter int MAX_FRAMES = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    drlm_frame_if.sink    frame,
    drlm_result_if.source result,
    drlm_cfg_if.sink      cfg
);

    cfg_t    cfg_reg, cfg_next;
    cmd_t    cmd;
    status_t status;

    // Register writes are never back-pressured.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_ENABLE:        cfg_next.enable        = cfg.data[0];
                REG_CHANNEL_COUNT: cfg_next.channel_count = cfg.data[CHAN_BITS-1:0];
                REG_DECIMATION:    cfg_next.decimation    = cfg.data[DEC_BITS-1:0];
                REG_GAIN:          cfg_next.gain          = cfg.data[GAIN_BITS-1:0];
                default:           cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The controller owns the input handshake and sequences the datapath.
    drlm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .frame_valid (frame.valid),
        .frame_ready (frame.ready),
        .status      (status),
        .cmd         (cmd)
    );

    // The datapath holds the block sums, the serial divide and root units and
    // the output register that drives the result channel.
    drlm_datapath #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .status       (status),
        .sample_left  (frame.sample_left),
        .sample_right (frame.sample_right),
        .last_frame   (frame.last_frame),
        .res_ready    (result.ready),
        .res_valid    (result.valid),
        .rms_left     (result.rms_left),
        .rms_right    (result.rms_right),
        .saturated    (result.saturated)
    );

endmodule
